[src/ela_pkg.sv]
`timescale 1ns / 1ps
package ela_pkg;

  // Field widths
  localparam int FRAC_BITS   = 8;
  localparam int COUNT_BITS  = 16;
  localparam int POS_BITS    = COUNT_BITS + FRAC_BITS;
  localparam int TICK_BITS   = 32;
  localparam int GLITCH_BITS = 3;

  // Derived datapath widths
  localparam int DIFF_BITS  = COUNT_BITS + 1;   // whole-count difference
  localparam int QMAG_BITS  = POS_BITS + 1;     // |numerator|, |slope|
  localparam int SLOPE_BITS = POS_BITS + 2;     // signed slope
  localparam int PROD_BITS  = QMAG_BITS + TICK_BITS;
  localparam int EST_BITS   = POS_BITS + 3;     // unclamped estimate

  localparam int DIV_CNT_BITS = $clog2(QMAG_BITS);
  localparam int MUL_CNT_BITS = $clog2(TICK_BITS);

  // Reset values
  localparam int TICKS_PER_SECOND = 100;
  localparam logic [GLITCH_BITS-1:0] GLITCH_RESET = GLITCH_BITS'(6);

  // Estimate limits
  localparam logic [POS_BITS-1:0] POS_MAX = {1'b0, {(POS_BITS-1){1'b1}}};
  localparam logic [POS_BITS-1:0] POS_MIN = {1'b1, {(POS_BITS-1){1'b0}}};

  // Register map: word select bit of paddr
  localparam int ADDR_BITS = 3;
  localparam logic REG_GLITCH_STEPS = 1'b0;

endpackage

[src/ela_divider.sv]
`timescale 1ns / 1ps
module ela_divider (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [ela_pkg::QMAG_BITS-1:0] num_mag,
  input  logic [ela_pkg::TICK_BITS-1:0] den_mag,
  output logic [ela_pkg::QMAG_BITS-1:0] quotient,
  output logic                          done
);
  import ela_pkg::*;

  logic                    busy;
  logic [DIV_CNT_BITS-1:0] count;
  logic [QMAG_BITS-1:0]    qsh;   // numerator bits out at top, quotient bits in at bottom
  logic [TICK_BITS-1:0]    rem;
  logic [TICK_BITS-1:0]    den;
  logic [TICK_BITS:0]      trial;
  logic                    take;

  // restoring step: one quotient bit per cycle
  always_comb begin
    trial = {rem, qsh[QMAG_BITS-1]} - {1'b0, den};
    take  = !trial[TICK_BITS];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == DIV_CNT_BITS'(QMAG_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      qsh <= num_mag;
      den <= den_mag;
      rem <= '0;
    end else if (busy) begin
      qsh <= {qsh[QMAG_BITS-2:0], take};
      if (take) begin
        rem <= trial[TICK_BITS-1:0];
      end else begin
        rem <= {rem[TICK_BITS-2:0], qsh[QMAG_BITS-1]};
      end
    end
  end

  assign quotient = qsh;

endmodule

[src/ela_multiplier.sv]
`timescale 1ns / 1ps
module ela_multiplier (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [ela_pkg::QMAG_BITS-1:0] a_mag,
  input  logic [ela_pkg::TICK_BITS-1:0] b_mag,
  output logic [ela_pkg::PROD_BITS-1:0] product,
  output logic                          done
);
  import ela_pkg::*;

  logic                    busy;
  logic [MUL_CNT_BITS-1:0] count;
  logic [QMAG_BITS-1:0]    a;
  logic [QMAG_BITS-1:0]    hi;
  logic [TICK_BITS-1:0]    lo;    // multiplier bits shift out, product bits shift in
  logic [QMAG_BITS:0]      sum;

  // shift-add: one multiplier bit per cycle, LSB first
  always_comb begin
    sum = {1'b0, hi} + (lo[0] ? {1'b0, a} : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == MUL_CNT_BITS'(TICK_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a  <= a_mag;
      hi <= '0;
      lo <= b_mag;
    end else if (busy) begin
      hi <= sum[QMAG_BITS:1];
      lo <= {sum[0], lo[TICK_BITS-1:1]};
    end
  end

  assign product = {hi, lo};

endmodule

[src/encoder_linear_extrapolator_unit.sv]
`timescale 1ns / 1ps
// Linear extrapolating sample-and-hold filter for a quantized encoder.
//
// Input channel (in_valid / in_stall): one item is an encoder reading
// sensor_counts (signed counts) and its sample_tick. Output channel
// (out_valid / out_stall): one item per input item, position_estimate
// (signed, 8 fraction bits, saturated) with glitch_rejected / divide_fault.
//
// Timing: a reading that shifts the history with a nonzero tick gap runs
// the bit-serial slope divider (one quotient bit per step) and then the
// bit-serial extrapolation multiplier (one tick bit per step). Any other
// item skips the divider. The block takes no new item while one is in work;
// in_stall is low only while the sequencer is idle.
//
// The output register holds a finished item while out_stall is high, and
// the next item is accepted and worked on meanwhile; it waits in the last
// step until the output register frees up.
// Reset (rst, synchronous): history cleared, newer tick = one second of
// ticks, slope 0, glitch_steps = 6, no output pending.
// glitch_steps sits at APB byte address 0; write it only while idle.
module encoder_linear_extrapolator_unit (
  input  logic                               clk,
  input  logic                               rst,
  // input items
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [ela_pkg::COUNT_BITS-1:0] sensor_counts,
  input  logic [ela_pkg::TICK_BITS-1:0]      sample_tick,
  // result items
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [ela_pkg::POS_BITS-1:0] position_estimate,
  output logic                               glitch_rejected,
  output logic                               divide_fault,
  // configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ela_pkg::ADDR_BITS-1:0]      paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import ela_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_EVAL   = 3'd1;  // compare, reject or shift history
  localparam logic [2:0] ST_DIV    = 3'd2;  // serial slope divide
  localparam logic [2:0] ST_MSTART = 3'd3;  // load multiplier
  localparam logic [2:0] ST_MUL    = 3'd4;  // serial slope * elapsed
  localparam logic [2:0] ST_FIN    = 3'd5;  // add, clamp, hand to output reg

  logic [2:0] state;

  // configuration
  logic [GLITCH_BITS-1:0] glitch_steps;

  // history
  logic [POS_BITS-1:0]   older_pos;
  logic [POS_BITS-1:0]   newer_pos;
  logic [TICK_BITS-1:0]  older_tick;
  logic [TICK_BITS-1:0]  newer_tick;
  logic [SLOPE_BITS-1:0] slope;

  // captured item and per-item flags
  logic [COUNT_BITS-1:0] sensor_r;
  logic [TICK_BITS-1:0]  tick_r;
  logic                  glitch_r;
  logic                  fault_r;
  logic                  div_neg;
  logic                  prod_neg;

  // evaluate step
  logic [POS_BITS-1:0]  s_pos;
  logic                 changed;
  logic [DIFF_BITS-1:0] k_diff;
  logic [DIFF_BITS-1:0] k_mag;
  logic                 near;
  logic [POS_BITS:0]    avg_sum;
  logic [QMAG_BITS-1:0] num;
  logic [QMAG_BITS-1:0] num_mag;
  logic [TICK_BITS-1:0] gap;
  logic [TICK_BITS-1:0] gap_mag;

  // extrapolation
  logic [TICK_BITS-1:0]  elapsed;
  logic [TICK_BITS-1:0]  el_mag;
  logic [SLOPE_BITS-1:0] slope_abs;
  logic [EST_BITS-1:0]   term;
  logic [EST_BITS-1:0]   est_sum;
  logic                  prod_big;
  logic [POS_BITS-1:0]   est;

  // serial units
  logic                 div_start;
  logic                 div_done;
  logic [QMAG_BITS-1:0] div_q;
  logic                 mul_start;
  logic                 mul_done;
  logic [PROD_BITS-1:0] mul_p;

  logic out_free;

  // ---------------- APB ----------------
  assign pready = 1'b1;

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_GLITCH_STEPS) begin
      prdata = {{(32-GLITCH_BITS){1'b0}}, glitch_steps};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      glitch_steps <= GLITCH_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_GLITCH_STEPS) begin
      glitch_steps <= pwdata[GLITCH_BITS-1:0];
    end
  end

  // ---------------- evaluate ----------------
  always_comb begin
    s_pos   = {sensor_r, {FRAC_BITS{1'b0}}};
    changed = s_pos != newer_pos;
    // new reading has no fraction, so the older one must not either;
    // k = whole-count distance to the older reading
    k_diff  = {older_pos[POS_BITS-1], older_pos[POS_BITS-1:FRAC_BITS]}
            - {sensor_r[COUNT_BITS-1], sensor_r};
    k_mag   = k_diff[DIFF_BITS-1] ? (~k_diff + 1'b1) : k_diff;
    near    = (older_pos[FRAC_BITS-1:0] == '0)
           && (k_mag <= {{(DIFF_BITS-GLITCH_BITS){1'b0}}, glitch_steps});
    // floor average of the two stored positions
    avg_sum = {newer_pos[POS_BITS-1], newer_pos} + {older_pos[POS_BITS-1], older_pos};
    // slope numerator and denominator for a history shift
    num     = {s_pos[POS_BITS-1], s_pos} - {newer_pos[POS_BITS-1], newer_pos};
    num_mag = num[QMAG_BITS-1] ? (~num + 1'b1) : num;
    gap     = tick_r - newer_tick;
    gap_mag = gap[TICK_BITS-1] ? (~gap + 1'b1) : gap;
  end

  // ---------------- extrapolate ----------------
  always_comb begin
    elapsed   = tick_r - newer_tick;
    el_mag    = elapsed[TICK_BITS-1] ? (~elapsed + 1'b1) : elapsed;
    slope_abs = slope[SLOPE_BITS-1] ? (~slope + 1'b1) : slope;
  end

  always_comb begin
    // |newer| < 2^(POS_BITS-1), so any product at or above 2^QMAG_BITS saturates
    prod_big = |mul_p[PROD_BITS-1:QMAG_BITS];
    term     = {2'b00, mul_p[QMAG_BITS-1:0]};
    if (prod_neg) begin
      term = ~term + 1'b1;
    end
    est_sum = {{(EST_BITS-POS_BITS){newer_pos[POS_BITS-1]}}, newer_pos} + term;
    if (prod_big) begin
      est = prod_neg ? POS_MIN : POS_MAX;
    end else if (!est_sum[EST_BITS-1] && (|est_sum[EST_BITS-2:POS_BITS-1])) begin
      est = POS_MAX;
    end else if (est_sum[EST_BITS-1] && !(&est_sum[EST_BITS-2:POS_BITS-1])) begin
      est = POS_MIN;
    end else begin
      est = est_sum[POS_BITS-1:0];
    end
  end

  // ---------------- sequencer ----------------
  assign in_stall  = state != ST_IDLE;
  assign out_free  = !out_valid || !out_stall;
  assign div_start = (state == ST_EVAL) && changed && !near && (gap != '0);
  assign mul_start = state == ST_MSTART;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      older_pos  <= '0;
      newer_pos  <= '0;
      older_tick <= '0;
      newer_tick <= TICK_BITS'(TICKS_PER_SECOND);
      slope      <= '0;
      glitch_r   <= 1'b0;
      fault_r    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // load a finished item, else drop one taken by the receiver
      if (state == ST_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          glitch_r <= 1'b0;
          fault_r  <= 1'b0;
          state    <= ST_MSTART;
          if (changed) begin
            if (near) begin
              // jitter: pull newer halfway back, drop the slope
              glitch_r  <= 1'b1;
              slope     <= '0;
              newer_pos <= avg_sum[POS_BITS:1];
            end else begin
              older_pos  <= newer_pos;
              older_tick <= newer_tick;
              newer_pos  <= s_pos;
              newer_tick <= tick_r;
              if (gap == '0) begin
                fault_r <= 1'b1;
                slope   <= '0;
              end else begin
                state <= ST_DIV;
              end
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            slope <= div_neg ? (~{1'b0, div_q} + 1'b1) : {1'b0, div_q};
            state <= ST_MSTART;
          end
        end
        ST_MSTART: begin
          state <= ST_MUL;
        end
        ST_MUL: begin
          if (mul_done) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      sensor_r <= sensor_counts;
      tick_r   <= sample_tick;
    end
    if (div_start) begin
      div_neg <= num[QMAG_BITS-1] ^ gap[TICK_BITS-1];
    end
    if (mul_start) begin
      prod_neg <= slope[SLOPE_BITS-1] ^ elapsed[TICK_BITS-1];
    end
    if (state == ST_FIN && out_free) begin
      position_estimate <= est;
      glitch_rejected   <= glitch_r;
      divide_fault      <= fault_r;
    end
  end

  ela_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .num_mag  (num_mag),
    .den_mag  (gap_mag),
    .quotient (div_q),
    .done     (div_done)
  );

  ela_multiplier u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a_mag   (slope_abs[QMAG_BITS-1:0]),
    .b_mag   (el_mag),
    .product (mul_p),
    .done    (mul_done)
  );

  // ---------------- checks ----------------
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(glitch_rejected && divide_fault))
    else $error("glitch and divide fault on the same item");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider finished outside divide step");

  a_mul_done_in_mul: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> state == ST_MUL)
    else $error("multiplier finished outside multiply step");

  a_glitch_zero_slope: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && glitch_r) |-> slope == '0)
    else $error("slope not cleared after rejected reading");

  a_fault_zero_prod: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && fault_r) |-> mul_p == '0)
    else $error("nonzero extrapolation after zero tick gap");

endmodule

[tb/tb_encoder_linear_extrapolator_unit.sv]
`timescale 1ns / 1ps
module tb_encoder_linear_extrapolator_unit;
  import ela_pkg::*;

  // Fixed-point helpers, positions carry FRAC_BITS fraction bits
  localparam longint UNIT = longint'(1) << FRAC_BITS;
  localparam longint PMAX = (longint'(1) << (POS_BITS - 1)) - 1;
  localparam longint PMIN = -PMAX - 1;
  // |slope| * |elapsed| above this is taken as overflow
  localparam longint unsigned PRODUCT_LIMIT = 64'h4000_0000_0000_0000;

  // Register map: glitch_steps word, and a word that decodes to nothing
  localparam logic [ADDR_BITS-1:0] GLITCH_ADDR = {REG_GLITCH_STEPS, 2'b00};
  localparam logic [ADDR_BITS-1:0] UNUSED_ADDR = {!REG_GLITCH_STEPS, 2'b00};

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int HOLD_CYCLES  = 600;
  localparam int PHASE_ITEMS  = 310;
  localparam int SETTLE_TICKS = 80;   // longer than the worst-case path from accept to out_valid

  typedef struct packed {
    logic [POS_BITS-1:0] position;
    logic                glitch;
    logic                fault;
  } estimate_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [COUNT_BITS-1:0] sensor_counts = '0;
  logic [TICK_BITS-1:0]  sample_tick = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [POS_BITS-1:0]   position_estimate;
  logic                  glitch_rejected;
  logic                  divide_fault;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [ADDR_BITS-1:0]  paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  // Predicted filter state
  longint               hist_older;
  longint               hist_newer;
  logic [TICK_BITS-1:0] tick_older;
  logic [TICK_BITS-1:0] tick_newer;
  longint               slope_per_tick;
  logic [2:0]           glitch_window;

  estimate_t   pending_estimates[$];
  int          mismatch_count = 0;
  int unsigned cycle_count = 0;

  // Idle knobs: sender gaps, receiver waits, long output hold
  bit          feed_idle = 1'b1;
  bit          drain_idle = 1'b1;
  logic        hold_output = 1'b0;
  int unsigned result_wait = 0;
  int unsigned waited = 0;
  int          jitter_run = 0;

  encoder_linear_extrapolator_unit i_dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .sensor_counts     (sensor_counts),
    .sample_tick       (sample_tick),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .position_estimate (position_estimate),
    .glitch_rejected   (glitch_rejected),
    .divide_fault      (divide_fault),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic longint magnitude(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Tick difference mod 2^32, read as signed
  function automatic longint tick_span(input logic [TICK_BITS-1:0] a,
                                       input logic [TICK_BITS-1:0] b);
    logic [TICK_BITS-1:0] d;
    d = a - b;
    return longint'($signed(d));
  endfunction

  function automatic void reset_history();
    hist_older     = 0;
    hist_newer     = 0;
    tick_older     = '0;
    tick_newer     = TICK_BITS'(TICKS_PER_SECOND);
    slope_per_tick = 0;
    glitch_window  = GLITCH_RESET;
  endfunction

  function automatic void apply_register(input logic [ADDR_BITS-1:0] addr,
                                         input logic [31:0] data);
    if (addr == GLITCH_ADDR) glitch_window = data[2:0];
  endfunction

  // Updates the predicted state for one reading and returns its result
  function automatic estimate_t extrapolate_reading(
      input logic signed [COUNT_BITS-1:0] counts, input logic [TICK_BITS-1:0] tick);
    estimate_t             result;
    longint                reading, offset, pair_sum, halved, gap;
    longint                elapsed, product, estimate;
    longint unsigned       slope_mag, elapsed_mag;
    bit                    near;
    reading = longint'(counts) * UNIT;
    result.glitch = 1'b0;
    result.fault  = 1'b0;
    if (reading != hist_newer) begin
      // jitter: whole-count distance to older reading within the window
      offset = hist_older - reading;
      near = 1'b0;
      if (offset % UNIT == 0) near = magnitude(offset / UNIT) <= longint'(glitch_window);
      if (near) begin
        pair_sum = hist_newer + hist_older;
        halved = pair_sum / 2;
        if (pair_sum % 2 != 0 && pair_sum < 0) halved--;   // floor
        result.glitch  = 1'b1;
        slope_per_tick = 0;
        hist_newer     = halved;
      end else begin
        hist_older = hist_newer;
        tick_older = tick_newer;
        hist_newer = reading;
        tick_newer = tick;
        gap = tick_span(tick_newer, tick_older);
        if (gap == 0) begin
          result.fault   = 1'b1;
          slope_per_tick = 0;
        end else begin
          slope_per_tick = (hist_newer - hist_older) / gap;
        end
      end
    end
    elapsed     = tick_span(tick, tick_newer);
    slope_mag   = magnitude(slope_per_tick);
    elapsed_mag = magnitude(elapsed);
    if (slope_mag != 0 && elapsed_mag > PRODUCT_LIMIT / slope_mag) begin
      product = ((slope_per_tick < 0) != (elapsed < 0)) ? PMIN - UNIT : PMAX + UNIT;
      product = product * 4;
    end else begin
      product = slope_per_tick * elapsed;
    end
    if (product > PMAX * 4) product = PMAX * 4;
    if (product < PMIN * 4) product = PMIN * 4;
    estimate = hist_newer + product;
    if (estimate > PMAX) estimate = PMAX;
    if (estimate < PMIN) estimate = PMIN;
    result.position = estimate[POS_BITS-1:0];
    return result;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  task automatic note_mismatch(input string what, input longint want, input longint got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t %s: expected %0d, got %0d", $time, what, want, got);
  endtask

  // Offers one reading after a random gap; valid stays high across
  // back-to-back items so it never toggles within one step.
  task automatic send_reading(input logic [COUNT_BITS-1:0] counts,
                              input logic [TICK_BITS-1:0] tick);
    int unsigned gap;
    estimate_t   predicted;
    gap = feed_idle ? $urandom_range(0, 10) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    sensor_counts <= counts;
    sample_tick   <= tick;
    do @(posedge clk); while (in_stall);
    predicted = extrapolate_reading($signed(counts), tick);
    pending_estimates.insert(pending_estimates.size(), predicted);
  endtask

  // Drop valid and wait until every predicted result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_estimates.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input logic [ADDR_BITS-1:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    apply_register(addr, data);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_register();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= GLITCH_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== 32'(glitch_window))
      note_mismatch("glitch_steps readback", longint'(glitch_window), longint'(prdata));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Random reading, steered by the predicted state so that most items are
  // plausible motion, jitter runs, repeats and zero tick gaps.
  task automatic draw_reading(output logic [COUNT_BITS-1:0] counts,
                              output logic [TICK_BITS-1:0] tick);
    int unsigned pick;
    int          level, span;
    bit          whole_older;
    pick        = $urandom_range(0, 99);
    level       = int'(hist_newer >>> FRAC_BITS);
    whole_older = (hist_older % UNIT) == 0;
    span        = int'(glitch_window);
    tick        = tick_newer + $urandom_range(1, 20);
    if (jitter_run > 0 && whole_older) begin
      // repeated jitter halves newer toward older, reaching odd sums
      jitter_run--;
      level = int'(hist_older >>> FRAC_BITS) + int'($urandom_range(0, 2 * span)) - span;
    end else if (pick < 8) begin
      level = int'($urandom_range(0, 65535)) - 32768;
      tick  = $urandom;
    end else if (pick < 20) begin
      // same reading, extrapolate a little forward or back
      tick = tick_newer + $urandom_range(0, 60) - 10;
    end else if (pick < 40) begin
      if (pick < 24) jitter_run = $urandom_range(6, 12);
      if (whole_older)
        level = int'(hist_older >>> FRAC_BITS) + int'($urandom_range(0, 2 * span + 2))
                - span - 1;
      else
        level = level + int'($urandom_range(0, 2)) - 1;
    end else if (pick < 48) begin
      tick  = tick_newer;
      level = level + int'($urandom_range(0, 800)) - 400;
    end else if (pick < 90) begin
      level = level + int'($urandom_range(0, 600)) - 300;
    end else begin
      level = level + int'($urandom_range(0, 2000)) - 1000;
      tick  = tick_newer + $urandom;
    end
    if (level > 32767) level = 32767;
    if (level < -32768) level = -32768;
    counts = COUNT_BITS'(level);
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: each item waits a drawn number of cycles once it shows
  // up, or the whole hold while the long hold is on.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : result_check
    estimate_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pending_estimates.size() == 0) begin
          note_mismatch("result with nothing pending, position", 0,
                        longint'($signed(position_estimate)));
        end else begin
          want = pending_estimates.pop_front();
          if (position_estimate !== want.position)
            note_mismatch("position_estimate", longint'($signed(want.position)),
                          longint'($signed(position_estimate)));
          if (glitch_rejected !== want.glitch)
            note_mismatch("glitch_rejected", longint'(want.glitch), longint'(glitch_rejected));
          if (divide_fault !== want.fault)
            note_mismatch("divide_fault", longint'(want.fault), longint'(divide_fault));
        end
        result_wait = drain_idle ? $urandom_range(0, 10) : 0;
        waited      = 0;
      end else if (out_valid) begin
        waited++;
      end
      out_stall <= hold_output || (waited < result_wait);
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset value, write/readback, a write to an unmapped word
  task automatic test_register_access();
    check_register();
    write_register(GLITCH_ADDR, 32'd7);
    check_register();
    write_register(UNUSED_ADDR, $urandom);
    check_register();
    write_register(GLITCH_ADDR, {29'($urandom_range(0, 32'h1FFF_FFFF)), 3'd0});
    check_register();
    write_register(GLITCH_ADDR, 32'(GLITCH_RESET));
    check_register();
  endtask

  // Reading equal to the reset history: nothing moves
  task automatic test_steady_start();
    send_reading(16'd0, 32'd100);
    send_reading(16'd0, 32'd37);
  endtask

  // Full-scale readings, tick wrap, saturation both ways
  task automatic test_field_extremes();
    send_reading(16'h7FFF, 32'd200);
    send_reading(16'h8000, 32'd201);
    send_reading(16'h8000, 32'hFFFF_FFFF);
    send_reading(16'h8000, 32'd0);
    send_reading(16'h7FFF, 32'h8000_0000);
    send_reading(16'd1, 32'h7FFF_FFFF);
  endtask

  // Window edge at reset width 6: k = 6 and k = 0 rejected, k = 7 shifts
  task automatic test_jitter_window();
    send_reading(16'd100, 32'd1000);
    send_reading(16'd200, 32'd1010);
    send_reading(16'd106, 32'd1011);
    send_reading(16'd100, 32'd1012);
    send_reading(16'd107, 32'd1013);
    send_reading(-16'sd5, 32'd1020);
  endtask

  // Two shifts in a row at the same tick both flag the divide fault
  task automatic test_zero_gap();
    send_reading(16'd50, 32'd2000);
    send_reading(16'd60, 32'd2000);
    send_reading(16'd61, 32'd2000);
  endtask

  // Tick before newer tick extrapolates backward
  task automatic test_backward_tick();
    send_reading(16'd80, 32'd3000);
    send_reading(16'd90, 32'd3010);
    send_reading(16'd90, 32'd2990);
  endtask

  // Output held for a long stretch while items keep coming: the block
  // fills and must stall its input.
  task automatic test_output_hold();
    logic [COUNT_BITS-1:0] counts;
    logic [TICK_BITS-1:0]  tick;
    feed_idle = 1'b0;
    fork
      begin
        hold_output <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_output <= 1'b0;
      end
    join_none
    for (int i = 0; i < 12; i++) begin
      draw_reading(counts, tick);
      send_reading(counts, tick);
    end
    drain_results();
    feed_idle = 1'b1;
  endtask

  // Random phases over several window widths, extremes included
  task automatic test_random_readings();
    logic [2:0]            widths[6] = '{3'd0, 3'd7, 3'd3, 3'd5, 3'd1, 3'd6};
    logic [COUNT_BITS-1:0] counts;
    logic [TICK_BITS-1:0]  tick;
    for (int phase = 0; phase < 6; phase++) begin
      drain_results();
      write_register(GLITCH_ADDR,
                     {29'($urandom_range(0, 32'h1FFF_FFFF)), widths[phase]});
      if (phase == 2) write_register(UNUSED_ADDR, $urandom);
      check_register();
      jitter_run = 0;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // re-draw idling every 50 items; some stretches run flat out
        if (i % 50 == 0) begin
          feed_idle  = $urandom_range(0, 3) != 0;
          drain_idle = $urandom_range(0, 3) != 0;
        end
        draw_reading(counts, tick);
        send_reading(counts, tick);
      end
    end
    drain_idle = 1'b1;
  endtask

  initial begin
    reset_history();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_register_access();
    test_steady_start();
    test_field_extremes();
    test_jitter_window();
    test_zero_gap();
    test_backward_tick();
    test_output_hold();
    test_random_readings();
    drain_results();
    repeat (SETTLE_TICKS) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[filelist.f]
src/ela_pkg.sv
src/ela_divider.sv
src/ela_multiplier.sv
src/encoder_linear_extrapolator_unit.sv
tb/tb_encoder_linear_extrapolator_unit.sv
